@@ src/plc_pkg.sv @@
// Shared constants and types of the posting list decoder.
`timescale 1ns / 1ps

package plc_pkg;

  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned CFG_DATA_W   = 32;
  localparam int unsigned COUNT_W      = 32;
  localparam int unsigned WORD_INDEX_W = 26;
  localparam int unsigned STATUS_W     = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ID   = 2'd2;

  localparam logic MODE_SPARSE = 1'b0;
  localparam logic MODE_DENSE  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_TOO_LONG = 2'd1;
  localparam logic [STATUS_W-1:0] ST_TRAILING = 2'd2;
  localparam logic [STATUS_W-1:0] ST_MISMATCH = 2'd3;

  localparam logic [6:0] VARINT_PAYLOAD_MASK = 7'h7f;
  localparam int unsigned VARINT_BITS = 7;
  localparam int unsigned VARINT_CONT_BIT = 7;

  typedef struct packed {
    logic                id_valid;
    logic                list_end;
    logic [STATUS_W-1:0] status;
  } out_flags_t;

endpackage

@@ src/plc_in_if.sv @@
// Input channel: one chunk word per handshake.
`timescale 1ns / 1ps

interface plc_in_if #(
  parameter int unsigned WORD_BITS = 64
);
  logic                 valid;
  logic                 ready;
  logic [WORD_BITS-1:0] chunk;
  logic                 last_chunk;

  modport source (output valid, output chunk, output last_chunk, input ready);
  modport sink   (input valid, input chunk, input last_chunk, output ready);
endinterface

@@ src/plc_out_if.sv @@
// Result channel: one decoded ID word per handshake.
`timescale 1ns / 1ps

interface plc_out_if #(
  parameter int unsigned ID_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic [ID_WIDTH-1:0]           doc_id;
  logic                          id_valid;
  logic                          list_end;
  logic [plc_pkg::STATUS_W-1:0]  status;

  modport source (output valid, output doc_id, output id_valid, output list_end,
                  output status, input ready);
  modport sink   (input valid, input doc_id, input id_valid, input list_end,
                  input status, output ready);
endinterface

@@ src/plc_add_unit.sv @@
// Shared ID adder with compare against the max_id limit.
`timescale 1ns / 1ps

module plc_add_unit #(
  parameter int unsigned ID_WIDTH = 32
) (
  input  logic [ID_WIDTH-1:0]            a_i,
  input  logic [ID_WIDTH-1:0]            b_i,
  input  logic [plc_pkg::CFG_DATA_W-1:0] limit_i,
  output logic [ID_WIDTH-1:0]            sum_o,
  output logic                           le_o
);

  localparam int unsigned CMP_W =
    (ID_WIDTH > plc_pkg::CFG_DATA_W) ? ID_WIDTH : plc_pkg::CFG_DATA_W;

  assign sum_o = a_i + b_i;  // wraps at ID_WIDTH
  assign le_o  = CMP_W'(sum_o) <= CMP_W'(limit_i);

endmodule

@@ src/plc_out_buf.sv @@
// Output register between the sequencer and the result channel.
`timescale 1ns / 1ps

module plc_out_buf #(
  parameter int unsigned ID_WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  logic [ID_WIDTH-1:0]   doc_id_i,
  input  plc_pkg::out_flags_t   flags_i,
  output logic                  free_o,
  plc_out_if.source             out_if
);

  logic                valid_q;
  logic [ID_WIDTH-1:0] doc_q;
  plc_pkg::out_flags_t flags_q;

  // free when empty or the held word leaves this cycle
  assign free_o = !valid_q || out_if.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (push_i) begin
      valid_q <= 1'b1;
    end else if (out_if.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      doc_q   <= doc_id_i;
      flags_q <= flags_i;
    end
  end

  assign out_if.valid    = valid_q;
  assign out_if.doc_id   = doc_q;
  assign out_if.id_valid = flags_q.id_valid;
  assign out_if.list_end = flags_q.list_end;
  assign out_if.status   = flags_q.status;

endmodule

@@ src/posting_list_decoder_top.sv @@
// Sparse: each varint byte passes through accept, decode and flush; not ready meanwhile.
// Dense: one bit tested per cycle by the shared adder, except while a hit waits on the output register.
// Result stalls on the output channel also stall the dense scan and the flush step.
// Results leave through an output register; a word appears in the cycle after it is pushed.
// Async active-low reset clears config and list state; no clearing pass.
`timescale 1ns / 1ps

module posting_list_decoder_top #(
  parameter int unsigned ID_WIDTH  = 32,
  parameter int unsigned WORD_BITS = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [plc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [plc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  plc_in_if.sink                         in_if,
  plc_out_if.source                      out_if
);

  localparam int unsigned VB     = (ID_WIDTH + 6) / 7;  // varint byte limit
  localparam int unsigned IDX_W  = $clog2(VB);
  localparam int unsigned SH_W   = $clog2(7 * VB);
  localparam int unsigned BIT_W  = $clog2(WORD_BITS);
  localparam int unsigned PROD_W = plc_pkg::WORD_INDEX_W + $clog2(WORD_BITS + 1);
  localparam int unsigned EXT_W  = (ID_WIDTH > PROD_W) ? ID_WIDTH : PROD_W;
  localparam int unsigned CW     = plc_pkg::COUNT_W;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SPARSE = 2'd1;
  localparam logic [1:0] S_DENSE  = 2'd2;
  localparam logic [1:0] S_FLUSH  = 2'd3;

  // configuration
  logic                           mode_q;
  logic [CW-1:0]                  exp_q;
  logic [plc_pkg::CFG_DATA_W-1:0] max_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= plc_pkg::MODE_SPARSE;
      exp_q  <= '0;
      max_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        plc_pkg::CFG_MODE:     mode_q <= cfg_data_i[0];
        plc_pkg::CFG_EXPECTED: exp_q  <= cfg_data_i[CW-1:0];
        plc_pkg::CFG_MAX_ID:   max_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // list state
  logic [ID_WIDTH-1:0]               accum_q, accum_d;
  logic [IDX_W-1:0]                  idx_q, idx_d;
  logic [ID_WIDTH-1:0]               run_q, run_d;
  logic [CW-1:0]                     ids_q, ids_d;
  logic [plc_pkg::WORD_INDEX_W-1:0]  widx_q, widx_d;
  logic [plc_pkg::STATUS_W-1:0]      err_q, err_d;

  // sequencer
  logic [1:0]           state_q, state_d;
  logic [WORD_BITS-1:0] chunk_q, chunk_d;
  logic                 last_q, last_d;
  logic                 ign_q, ign_d;
  logic                 mode_l_q, mode_l_d;
  logic [ID_WIDTH-1:0]  base_q, base_d;
  logic [BIT_W-1:0]     bit_q, bit_d;
  logic                 pend_v_q, pend_v_d;
  logic [ID_WIDTH-1:0]  pend_id_q, pend_id_d;

  // shared unit
  logic [ID_WIDTH-1:0] add_a, add_b, add_sum;
  logic                add_le;

  plc_add_unit #(.ID_WIDTH(ID_WIDTH)) u_add (
    .a_i     (add_a),
    .b_i     (add_b),
    .limit_i (max_q),
    .sum_o   (add_sum),
    .le_o    (add_le)
  );

  // output register
  logic                push;
  logic [ID_WIDTH-1:0] push_doc;
  plc_pkg::out_flags_t push_flags;
  logic                out_free;

  plc_out_buf #(.ID_WIDTH(ID_WIDTH)) u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .doc_id_i (push_doc),
    .flags_i  (push_flags),
    .free_o   (out_free),
    .out_if   (out_if)
  );

  assign in_if.ready = (state_q == S_IDLE);

  logic [6:0]                   vbyte;
  logic [SH_W-1:0]              sh_amt;
  logic [ID_WIDTH-1:0]          acc_new;
  logic [EXT_W-1:0]             prod;
  logic [plc_pkg::STATUS_W-1:0] end_status;
  logic                         hit;
  logic                         need_push;

  function automatic logic [6:0] in_chunk_byte(input logic [7:0] b);
    in_chunk_byte = b[6:0] & plc_pkg::VARINT_PAYLOAD_MASK;
  endfunction

  assign vbyte   = in_chunk_byte(chunk_q[7:0]);
  assign sh_amt  = SH_W'(plc_pkg::VARINT_BITS * idx_q);
  assign acc_new = accum_q | (ID_WIDTH'(vbyte) << sh_amt);
  assign prod    = EXT_W'(widx_q) * EXT_W'(WORD_BITS);
  assign hit     = chunk_q[0] && add_le;

  always_comb begin
    if (state_q == S_DENSE) begin
      add_a = base_q;
      add_b = ID_WIDTH'(bit_q);
    end else begin
      add_a = (ids_q == '0) ? '0 : run_q;
      add_b = acc_new;
    end
  end

  always_comb begin
    if (ign_q) begin
      end_status = plc_pkg::ST_OK;
    end else if (mode_l_q == plc_pkg::MODE_DENSE) begin
      end_status = (ids_q != exp_q) ? plc_pkg::ST_MISMATCH : plc_pkg::ST_OK;
    end else if (err_q != plc_pkg::ST_OK) begin
      end_status = err_q;
    end else if (idx_q != '0 || ids_q != exp_q) begin
      end_status = plc_pkg::ST_MISMATCH;
    end else begin
      end_status = plc_pkg::ST_OK;
    end
  end

  assign need_push = pend_v_q || last_q;

  always_comb begin
    accum_d   = accum_q;
    idx_d     = idx_q;
    run_d     = run_q;
    ids_d     = ids_q;
    widx_d    = widx_q;
    err_d     = err_q;
    state_d   = state_q;
    chunk_d   = chunk_q;
    last_d    = last_q;
    ign_d     = ign_q;
    mode_l_d  = mode_l_q;
    base_d    = base_q;
    bit_d     = bit_q;
    pend_v_d  = pend_v_q;
    pend_id_d = pend_id_q;
    push       = 1'b0;
    push_doc   = pend_id_q;
    push_flags = '{id_valid: 1'b1, list_end: 1'b0, status: plc_pkg::ST_OK};

    case (state_q)
      S_IDLE: begin
        if (in_if.valid) begin
          chunk_d  = in_if.chunk;
          last_d   = in_if.last_chunk;
          mode_l_d = mode_q;
          ign_d    = (exp_q == '0);
          base_d   = prod[ID_WIDTH-1:0];
          bit_d    = '0;
          if (exp_q == '0) begin
            state_d = S_FLUSH;
          end else if (mode_q == plc_pkg::MODE_DENSE) begin
            state_d = S_DENSE;
          end else begin
            state_d = S_SPARSE;
          end
        end
      end

      S_SPARSE: begin
        if (err_q != plc_pkg::ST_OK) begin
          // sticky error: byte dropped
        end else if (ids_q == exp_q) begin
          err_d = plc_pkg::ST_TRAILING;
        end else if (!chunk_q[plc_pkg::VARINT_CONT_BIT]) begin
          run_d     = add_sum;
          pend_id_d = add_sum;
          pend_v_d  = 1'b1;
          ids_d     = ids_q + CW'(1);
          accum_d   = '0;
          idx_d     = '0;
        end else if (idx_q == IDX_W'(VB - 1)) begin
          err_d   = plc_pkg::ST_TOO_LONG;
          accum_d = '0;
          idx_d   = '0;
        end else begin
          accum_d = acc_new;
          idx_d   = idx_q + IDX_W'(1);
        end
        state_d = S_FLUSH;
      end

      S_DENSE: begin
        // a new hit needs the previous one moved out first
        if (!(hit && pend_v_q && !out_free)) begin
          if (hit) begin
            push      = pend_v_q;
            pend_id_d = add_sum;
            pend_v_d  = 1'b1;
            ids_d     = ids_q + CW'(1);
          end
          chunk_d = chunk_q >> 1;
          bit_d   = bit_q + BIT_W'(1);
          if (bit_q == BIT_W'(WORD_BITS - 1)) begin
            widx_d  = widx_q + plc_pkg::WORD_INDEX_W'(1);
            state_d = S_FLUSH;
          end
        end
      end

      S_FLUSH: begin
        if (!need_push || out_free) begin
          push       = need_push;
          push_doc   = pend_v_q ? pend_id_q : '0;
          push_flags = '{id_valid: pend_v_q, list_end: last_q,
                         status: last_q ? end_status : plc_pkg::ST_OK};
          pend_v_d   = 1'b0;
          if (last_q) begin
            accum_d = '0;
            idx_d   = '0;
            run_d   = '0;
            ids_d   = '0;
            widx_d  = '0;
            err_d   = plc_pkg::ST_OK;
          end
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      pend_v_q <= 1'b0;
      accum_q  <= '0;
      idx_q    <= '0;
      run_q    <= '0;
      ids_q    <= '0;
      widx_q   <= '0;
      err_q    <= plc_pkg::ST_OK;
      last_q   <= 1'b0;
      ign_q    <= 1'b0;
      mode_l_q <= plc_pkg::MODE_SPARSE;
      bit_q    <= '0;
    end else begin
      state_q  <= state_d;
      pend_v_q <= pend_v_d;
      accum_q  <= accum_d;
      idx_q    <= idx_d;
      run_q    <= run_d;
      ids_q    <= ids_d;
      widx_q   <= widx_d;
      err_q    <= err_d;
      last_q   <= last_d;
      ign_q    <= ign_d;
      mode_l_q <= mode_l_d;
      bit_q    <= bit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chunk_q   <= chunk_d;
    base_q    <= base_d;
    pend_id_q <= pend_id_d;
  end

endmodule
